[src/ihfs_pkg.sv]
`timescale 1ns / 1ps
package ihfs_pkg;
	typedef enum logic [3:0] {
		PH_SIG, PH_DONE, PH_BMP, PH_PCX, PH_PSIG, PH_PCHUNK, PH_PSKIP,
		PH_IHDR, PH_GIF, PH_JLEN, PH_JSKIP, PH_JMARK, PH_JSOF
	} phase_t;

	localparam logic [2:0] FMT_ERR  = 3'd0;
	localparam logic [2:0] FMT_UNK  = 3'd1;
	localparam logic [2:0] FMT_BMP  = 3'd2;
	localparam logic [2:0] FMT_PNG  = 3'd3;
	localparam logic [2:0] FMT_GIF  = 3'd4;
	localparam logic [2:0] FMT_WEBP = 3'd5;
	localparam logic [2:0] FMT_JPEG = 3'd6;
	localparam logic [2:0] FMT_PCX  = 3'd7;

	typedef struct packed {
		logic [2:0]  fmt;
		logic [31:0] w;
		logic [31:0] h;
		logic [7:0]  ch;
		logic [15:0] bpp;
		logic [7:0]  pal;
	} result_t;
endpackage

[src/ihfs_parser.sv]
`timescale 1ns / 1ps
module ihfs_parser
	import ihfs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	output logic        res_valid,
	output result_t     res
);
	phase_t      phase_q;
	logic [7:0]  pos_q;
	logic [32:0] skip_q;
	logic [63:0] sh_q;
	logic [7:0]  mark_q;
	logic        sent_q;
	logic [31:0] w_q, h_q;

	phase_t      phase_d;
	logic [7:0]  pos_d, mark_d;
	logic [32:0] skip_d;
	logic [31:0] w_d, h_d;
	logic [63:0] sh;
	logic [31:0] lo;
	logic        emit;
	result_t     r;
	logic [2:0]  f;
	logic [15:0] bc, len, x0, y0, x1, y1;
	logic [7:0]  ct, dep, pch;
	logic [32:0] skn;

	assign sh = {sh_q[55:0], data_byte};
	assign lo = sh[31:0];

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q + 8'd1;
		skip_d  = skip_q;
		mark_d  = mark_q;
		w_d     = w_q;
		h_d     = h_q;
		emit    = 1'b0;
		r       = '0;
		f       = FMT_UNK;
		bc  = {sh[7:0], sh[15:8]};
		len = sh[15:0];
		ct  = sh[7:0];
		dep = sh[15:8];
		pch = 8'd0;
		x0 = {sh[55:48], sh[63:56]};
		y0 = {sh[39:32], sh[47:40]};
		x1 = {sh[23:16], sh[31:24]};
		y1 = {sh[7:0], sh[15:8]};
		skn = skip_q;
		case (phase_q)
			PH_SIG: begin
				if (pos_q == 8'd3) begin
					if (sh[31:16] == 16'h424D) f = FMT_BMP;
					if (lo == 32'h89504E47) f = FMT_PNG;
					if (lo == 32'h47494638) f = FMT_GIF;
					if (lo == 32'h52494646) f = FMT_WEBP;
					else if (sh[31:16] == 16'hFFD8) f = FMT_JPEG;
					else if (lo == 32'h0A050108) f = FMT_PCX;
					case (f)
						FMT_BMP:  phase_d = PH_BMP;
						FMT_PCX:  phase_d = PH_PCX;
						FMT_PNG:  phase_d = PH_PSIG;
						FMT_GIF:  phase_d = PH_GIF;
						FMT_JPEG: begin
							mark_d  = (sh[15:8] == 8'hFF) ? sh[7:0] : 8'd0;
							phase_d = PH_JLEN;
							pos_d   = 8'd0;
						end
						default: begin
							emit  = 1'b1;
							r.fmt = f;
						end
					endcase
				end
			end
			PH_BMP: begin
				if (pos_q == 8'd21) w_d = {sh[7:0], sh[15:8], sh[23:16], sh[31:24]};
				else if (pos_q == 8'd25) h_d = {sh[7:0], sh[15:8], sh[23:16], sh[31:24]};
				else if (pos_q == 8'd29) begin
					emit  = 1'b1;
					r.fmt = FMT_BMP;
					r.w   = w_q;
					r.h   = h_q;
					if (bc == 16'd16 || bc == 16'd24 || bc == 16'd32) begin
						r.bpp = bc;
						r.ch  = (bc == 16'd16) ? 8'd3 : bc[10:3];
					end else if (bc == 16'd1 || bc == 16'd4 || bc == 16'd8) begin
						r.bpp = 16'd32;
						r.pal = bc[7:0];
						r.ch  = 8'd4;
					end else r.fmt = FMT_ERR;
				end
			end
			PH_PCX: begin
				if (pos_q == 8'd11) begin
					w_d = {{16{x1[15]}}, x1} - {{16{x0[15]}}, x0} + 32'd1;
					h_d = {{16{y1[15]}}, y1} - {{16{y0[15]}}, y0} + 32'd1;
				end else if (pos_q == 8'd65) begin
					emit  = 1'b1;
					r.fmt = (ct == 8'd1 || ct == 8'd3) ? FMT_PCX : FMT_ERR;
					r.w   = w_q;
					r.h   = h_q;
					r.ch  = 8'd3;
					r.bpp = 16'd24;
					r.pal = (ct == 8'd1) ? 8'd8 : 8'd0;
				end
			end
			PH_PSIG: begin
				if (pos_q == 8'd7) begin
					if (lo != 32'h0D0A1A0A) emit = 1'b1;
					else begin
						phase_d = PH_PCHUNK;
						pos_d   = 8'd0;
					end
				end
			end
			PH_PCHUNK: begin
				if (pos_q == 8'd7) begin
					if (lo == 32'h49484452) begin
						if (sh[63:32] != 32'd13) emit = 1'b1;
						else begin
							phase_d = PH_IHDR;
							pos_d   = 8'd0;
						end
					end else begin
						skip_d  = {1'b0, sh[63:32]} + 33'd4;
						phase_d = PH_PSKIP;
					end
				end
			end
			PH_PSKIP, PH_JSKIP: begin
				if (skip_q != '0) skn = skip_q - 33'd1;
				skip_d = skn;
				if (skn == '0) begin
					phase_d = (phase_q == PH_PSKIP) ? PH_PCHUNK : PH_JMARK;
					pos_d   = 8'd0;
				end
			end
			PH_IHDR: begin
				if (pos_q == 8'd3) w_d = lo;
				else if (pos_q == 8'd9) begin
					h_d   = sh[47:16];
					emit  = 1'b1;
					r.w   = w_q;
					r.h   = sh[47:16];
					case (ct)
						8'd0: pch = 8'd1;
						8'd2: pch = 8'd3;
						8'd3: pch = 8'd3;
						8'd4: pch = 8'd2;
						8'd6: pch = 8'd4;
						default: pch = 8'd0;
					endcase
					if (pch != 8'd0) begin
						r.fmt = FMT_PNG;
						r.ch  = pch;
						r.pal = (ct == 8'd3) ? dep : 8'd0;
						r.bpp = (ct == 8'd3 && dep != 8'd0) ? 16'd24 : dep * pch;
					end
				end
			end
			PH_GIF: begin
				if (pos_q == 8'd9) begin
					emit = 1'b1;
					if ((sh[47:40] == 8'h37 || sh[47:40] == 8'h39) && sh[39:32] == 8'h61) begin
						r.fmt = FMT_GIF;
						r.w   = {16'd0, sh[23:16], sh[31:24]};
						r.h   = {16'd0, sh[7:0], sh[15:8]};
						r.ch  = 8'd3;
						r.bpp = 16'd24;
						r.pal = 8'd8;
					end
				end
			end
			PH_JLEN: begin
				if (pos_q == 8'd1) begin
					pos_d = 8'd0;
					if (len < 16'd2) emit = 1'b1;
					else if (mark_q >= 8'hC0 && mark_q <= 8'hC2) begin
						if (len < 16'd8) emit = 1'b1;
						else phase_d = PH_JSOF;
					end else if (len == 16'd2) phase_d = PH_JMARK;
					else begin
						skip_d  = {17'd0, len - 16'd2};
						phase_d = PH_JSKIP;
					end
				end
			end
			PH_JMARK: begin
				if (pos_q == 8'd1) begin
					mark_d  = (sh[15:8] == 8'hFF) ? sh[7:0] : 8'd0;
					phase_d = PH_JLEN;
					pos_d   = 8'd0;
				end
			end
			PH_JSOF: begin
				if (pos_q == 8'd5) begin
					emit  = 1'b1;
					r.fmt = FMT_JPEG;
					r.w   = {16'd0, sh[23:8]};
					r.h   = {16'd0, sh[39:24]};
					r.ch  = sh[7:0];
					r.bpp = sh[7:0] * sh[47:40];
				end
			end
			default: pos_d = pos_q;
		endcase
		if (emit) phase_d = PH_DONE;
		if (end_of_file && !emit && !sent_q) begin
			emit = 1'b1;
			r    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SIG;
			pos_q     <= '0;
			skip_q    <= '0;
			sh_q      <= '0;
			mark_q    <= '0;
			sent_q    <= 1'b0;
			w_q       <= '0;
			h_q       <= '0;
			res_valid <= 1'b0;
			res       <= '0;
		end else begin
			res_valid <= 1'b0;
			if (step) begin
				res_valid <= emit;
				if (emit) res <= r;
				if (end_of_file) begin
					phase_q <= PH_SIG;
					pos_q   <= '0;
					skip_q  <= '0;
					sh_q    <= '0;
					mark_q  <= '0;
					sent_q  <= 1'b0;
					w_q     <= '0;
					h_q     <= '0;
				end else begin
					phase_q <= phase_d;
					pos_q   <= pos_d;
					skip_q  <= skip_d;
					sh_q    <= sh;
					mark_q  <= mark_d;
					sent_q  <= sent_q | emit;
					w_q     <= w_d;
					h_q     <= h_d;
				end
			end
		end
	end
endmodule

[src/image_header_format_sniffer_core.sv]
`timescale 1ns / 1ps
// A result passes from the input register through the parser's result register to the
// output register, or waits in the skid slot while the output is stalled.
// Throughput: one byte per cycle, set by the single-pass parser; the input holds
// only while output stall would leave no free slot for the next parser result.
// Reset (arst_n low) returns the parser to signature wait and drops held items.
module image_header_format_sniffer_core
	import ihfs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  format_code,
	output logic [31:0] width,
	output logic [31:0] height,
	output logic [7:0]  channels,
	output logic [15:0] bits_per_pixel,
	output logic [7:0]  palette_bits
);
	logic       v_s1;
	logic [7:0] b_s1;
	logic       e_s1;
	logic       pv;
	result_t    pr;
	logic       ov_q, sk_q;
	result_t    o_q, sk_r_q;
	logic       sk_n;
	logic       adv;

	// step the parser only if the skid slot is free after this edge
	always_comb begin
		if (!ov_q || !out_stall) sk_n = sk_q & pv;
		else sk_n = sk_q | pv;
	end
	assign adv      = !sk_n;
	assign in_stall = v_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			b_s1 <= '0;
			e_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
			b_s1 <= data_byte;
			e_s1 <= end_of_file;
		end
	end

	ihfs_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (v_s1 && adv),
		.data_byte  (b_s1),
		.end_of_file(e_s1),
		.res_valid  (pv),
		.res        (pr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q   <= 1'b0;
			sk_q   <= 1'b0;
			o_q    <= '0;
			sk_r_q <= '0;
		end else begin
			if (!ov_q || !out_stall) begin
				if (sk_q) begin
					ov_q <= 1'b1;
					o_q  <= sk_r_q;
					sk_q <= pv;
					if (pv) sk_r_q <= pr;
				end else begin
					ov_q <= pv;
					if (pv) o_q <= pr;
				end
			end else if (pv) begin
				sk_q   <= 1'b1;
				sk_r_q <= pr;
			end
		end
	end

	assign out_valid      = ov_q;
	assign format_code    = o_q.fmt;
	assign width          = o_q.w;
	assign height         = o_q.h;
	assign channels       = o_q.ch;
	assign bits_per_pixel = o_q.bpp;
	assign palette_bits   = o_q.pal;
endmodule
